// ===== rtl/lpf_pkg.sv =====
package lpf_pkg;

    // Default path capacity.
    localparam int unsigned MAX_POINTS_DEF = 1024;

    // Input item kinds.
    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_ODOM   = 2'd1;
    localparam logic [1:0] KIND_FOLLOW = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TURN_LIMIT = 3'd0;
    localparam logic [2:0] REG_TURN_RATE  = 3'd1;
    localparam logic [2:0] REG_YAW_GAIN   = 3'd2;
    localparam logic [2:0] REG_YAW_DECAY  = 3'd3;
    localparam logic [2:0] REG_YAW_LIMIT  = 3'd4;
    localparam logic [2:0] REG_SLOW_DIST  = 3'd5;
    localparam logic [2:0] REG_SPEED_LIM  = 3'd6;

    // Fixed-point constants.
    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic [17:0]        PI_Q16      = 18'd205887;
    localparam logic [17:0]        HALF_PI_Q16 = 18'd102944;
    localparam logic [16:0]        LOG2E_Q16   = 17'd94548;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SC_RD,
        ST_SC_DIF,
        ST_SC_MX,
        ST_SC_MY,
        ST_SC_CMP,
        ST_TGT,
        ST_DS_MX,
        ST_DS_MY,
        ST_DS_SUM,
        ST_DS_SQ,
        ST_AT_PRE,
        ST_AT_IT,
        ST_AT_FIN,
        ST_ERR,
        ST_EX_M1,
        ST_EX_M2,
        ST_EX_M3,
        ST_EX_H1,
        ST_EX_H2,
        ST_EX_END,
        ST_YW_M1,
        ST_YW_M2,
        ST_YW_SAT,
        ST_SP_M,
        ST_SP_LD,
        ST_SP_DIV,
        ST_OUT
    } lpf_state_t;

    // Arctangent table for the vectoring rotations, Q.16 radians.
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        unique case (i)
            4'd0:  v = 16'd51472;
            4'd1:  v = 16'd30386;
            4'd2:  v = 16'd16055;
            4'd3:  v = 16'd8150;
            4'd4:  v = 16'd4091;
            4'd5:  v = 16'd2047;
            4'd6:  v = 16'd1024;
            4'd7:  v = 16'd512;
            4'd8:  v = 16'd256;
            4'd9:  v = 16'd128;
            4'd10: v = 16'd64;
            4'd11: v = 16'd32;
            4'd12: v = 16'd16;
            4'd13: v = 16'd8;
            4'd14: v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

    // Polynomial coefficients for 2^-f, Q.16.
    function automatic logic [16:0] exp2_coef(input logic [2:0] k);
        logic [16:0] v;
        unique case (k)
            3'd0: v = 17'd65536;
            3'd1: v = 17'd45426;
            3'd2: v = 17'd15744;
            3'd3: v = 17'd3638;
            3'd4: v = 17'd630;
            3'd5: v = 17'd87;
            default: v = 17'd10;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/lpf_mul.sv =====
module lpf_mul (
    input  logic        aclk,
    input  logic [32:0] mul_a,
    input  logic [30:0] mul_b,
    output logic [63:0] mul_p
);
    // Shared unsigned multiplier with a registered product.
    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign mul_p = prod_reg;

endmodule

// ===== rtl/lookahead_path_follower.sv =====
// Path points and follow commands are accepted back to back in the idle state.
// An odometry word is processed in full before the next input word is accepted;
// the scan reads the stored points one at a time and squares their offsets on the
// shared multiplier, and the square root and division run one bit per cycle.
// Reset is synchronous and active low: it clears control state and loads the register
// defaults; the path store is not cleared and is valid only where written.
module lookahead_path_follower #(
    parameter int unsigned MAX_POINTS = lpf_pkg::MAX_POINTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // pos_x[31:0], pos_y[63:32], heading[78:64], follow_on[79]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        s_tlast,   // last_point
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // forward_speed[14:0], yaw_rate[30:15], target_x[62:31],
                                   // target_y[94:63], zero[95]
    output logic        m_tuser,   // turning_in_place
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpf_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    lpf_state_t state_reg, state_next;

    // Configuration registers.
    logic [14:0] turn_limit_reg;
    logic [15:0] turn_rate_reg;
    logic [14:0] yaw_gain_reg;
    logic [14:0] yaw_decay_reg;
    logic [14:0] yaw_limit_reg;
    logic [30:0] slow_dist_reg;
    logic [14:0] speed_lim_reg;

    // Path and follower state.
    logic [63:0]        path_mem [MAX_POINTS];
    logic [63:0]        rdata_reg;
    logic [CW-1:0]      load_reg;
    logic [CW-1:0]      search_reg;
    logic [CW-1:0]      idx_reg;
    logic               held_reg;
    logic               follow_reg;
    logic signed [31:0] look_x_reg, look_y_reg;

    // Latched odometry.
    logic signed [31:0] px_reg, py_reg;
    logic signed [14:0] hd_reg;

    // Working registers.
    logic [16:0]        sdx_reg, sdy_reg;
    logic [63:0]        acc_reg;
    logic               dx_neg_reg, dy_neg_reg, sh_reg;
    logic [30:0]        sx_reg, sy_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [19:0] z_reg;
    logic [3:0]         it_reg;
    logic [62:0]        rad_reg;
    logic [63:0]        r_reg;
    logic [4:0]         k_reg;
    logic [32:0]        d_reg;
    logic signed [14:0] angle_reg;
    logic [14:0]        aerr_reg;
    logic               err_neg_reg;
    logic [15:0]        f_reg;
    logic [4:0]         n_reg;
    logic [16:0]        p_reg;
    logic [2:0]         hk_reg;
    logic [16:0]        e_reg;
    logic [31:0]        rem_reg;
    logic [14:0]        lo_reg;
    logic [14:0]        q_reg;
    logic signed [15:0] yaw_reg;
    logic [14:0]        speed_reg;
    logic               turn_reg;

    // Output register.
    logic               m_valid_reg;
    logic [14:0]        o_speed_reg;
    logic [15:0]        o_yaw_reg;
    logic               o_turn_reg;
    logic [31:0]        o_tx_reg, o_ty_reg;

    // Shared multiplier.
    logic [32:0] mul_a;
    logic [30:0] mul_b;
    logic [63:0] mul_p;

    lpf_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    // Input word fields.
    logic               in_acc;
    logic [1:0]         in_kind;
    logic signed [31:0] in_x, in_y;
    logic signed [14:0] in_hd;
    logic               in_on;
    logic               out_free;

    assign in_acc   = s_tvalid && s_tready;
    assign in_kind  = s_tuser;
    assign in_x     = s_tdata[31:0];
    assign in_y     = s_tdata[63:32];
    assign in_hd    = s_tdata[78:64];
    assign in_on    = s_tdata[79];
    assign out_free = !m_valid_reg || m_tready;

    // Combinational datapath terms.
    logic               scan_last;
    logic               scan_skip;
    logic signed [32:0] sc_dx, sc_dy;
    logic [32:0]        sc_adx, sc_ady;
    logic               sc_out;
    logic [63:0]        sc_sq;
    logic               sc_hit;
    logic signed [32:0] tg_dx, tg_dy;
    logic [32:0]        tg_adx, tg_ady;
    logic               tg_sh;
    logic [63:0]        sq_bit, sq_try;
    logic               at_zero, at_big;
    logic signed [33:0] at_xs, at_ys, at_ymag;
    logic [17:0]        at_zc, at_zq;
    logic [14:0]        at_q;
    logic signed [16:0] er_raw, er_wrap;
    logic [16:0]        er_mag;
    logic               ex_big;
    logic [63:0]        yw_round;
    logic [35:0]        yw_m;
    logic [14:0]        yw_sat;
    logic [31:0]        dv_rem2;
    logic               dv_ge;
    logic               spd_full;

    always_comb begin
        scan_last = (idx_reg == CW'(1));
        scan_skip = (idx_reg >= load_reg);

        sc_dx  = 33'(signed'(rdata_reg[31:0])) - 33'(px_reg);
        sc_dy  = 33'(signed'(rdata_reg[63:32])) - 33'(py_reg);
        sc_adx = sc_dx[32] ? 33'(-sc_dx) : 33'(sc_dx);
        sc_ady = sc_dy[32] ? 33'(-sc_dy) : 33'(sc_dy);
        sc_out = (sc_adx >= 33'd131072) || (sc_ady >= 33'd131072);
        sc_sq  = acc_reg + mul_p;
        sc_hit = (sc_sq > 64'h4000_0000) && (sc_sq < 64'h4_0000_0000);

        tg_dx  = 33'(look_x_reg) - 33'(px_reg);
        tg_dy  = 33'(look_y_reg) - 33'(py_reg);
        tg_adx = tg_dx[32] ? 33'(-tg_dx) : 33'(tg_dx);
        tg_ady = tg_dy[32] ? 33'(-tg_dy) : 33'(tg_dy);
        tg_sh  = (tg_adx >= 33'h8000_0000) || (tg_ady >= 33'h8000_0000);

        sq_bit = 64'd1 << {k_reg, 1'b0};
        sq_try = r_reg + sq_bit;

        at_zero = (cx_reg == 34'sd0) && (cy_reg == 34'sd0);
        at_big  = (cx_reg >= 34'sd536870912) || (cy_reg >= 34'sd536870912);
        at_xs   = cx_reg >>> it_reg;
        at_ymag = cy_reg[33] ? -cy_reg : cy_reg;
        at_ys   = cy_reg[33] ? -(at_ymag >>> it_reg) : (at_ymag >>> it_reg);
        if (z_reg < 20'sd0) begin
            at_zc = 18'd0;
        end else if (z_reg > 20'(HALF_PI_Q16)) begin
            at_zc = HALF_PI_Q16;
        end else begin
            at_zc = z_reg[17:0];
        end
        at_zq = dx_neg_reg ? (PI_Q16 - at_zc) : at_zc;
        at_q  = 15'((at_zq + 18'd8) >> 4);

        er_raw = 17'(angle_reg) - 17'(hd_reg);
        if (er_raw > PI_Q12) begin
            er_wrap = er_raw - TWO_PI_Q12;
        end else if (er_raw < -PI_Q12) begin
            er_wrap = er_raw + TWO_PI_Q12;
        end else begin
            er_wrap = er_raw;
        end
        er_mag = er_wrap[16] ? 17'(-er_wrap) : 17'(er_wrap);

        ex_big = |mul_p[63:32];

        yw_round = mul_p + 64'h800_0000;
        yw_m     = yw_round[63:28];
        yw_sat   = (yw_m >= 36'(yaw_limit_reg)) ? yaw_limit_reg : yw_m[14:0];

        dv_rem2 = {rem_reg[30:0], lo_reg[it_reg]};
        dv_ge   = dv_rem2 >= 32'(slow_dist_reg);

        spd_full = d_reg >= 33'(slow_dist_reg);
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && in_kind == KIND_ODOM) begin
                    state_next = (held_reg && search_reg != '0) ? ST_SC_RD : ST_TGT;
                end
            end
            ST_SC_RD: begin
                if (scan_skip) begin
                    state_next = scan_last ? ST_TGT : ST_SC_RD;
                end else begin
                    state_next = ST_SC_DIF;
                end
            end
            ST_SC_DIF: begin
                if (sc_out) begin
                    state_next = scan_last ? ST_TGT : ST_SC_RD;
                end else begin
                    state_next = ST_SC_MX;
                end
            end
            ST_SC_MX:  state_next = ST_SC_MY;
            ST_SC_MY:  state_next = ST_SC_CMP;
            ST_SC_CMP: state_next = scan_last ? ST_TGT : ST_SC_RD;
            ST_TGT:    state_next = follow_reg ? ST_DS_MX : ST_OUT;
            ST_DS_MX:  state_next = ST_DS_MY;
            ST_DS_MY:  state_next = ST_DS_SUM;
            ST_DS_SUM: state_next = ST_DS_SQ;
            ST_DS_SQ:  state_next = (k_reg == 5'd0) ? ST_AT_PRE : ST_DS_SQ;
            ST_AT_PRE: begin
                if (at_zero) begin
                    state_next = ST_ERR;
                end else if (!at_big) begin
                    state_next = ST_AT_IT;
                end
            end
            ST_AT_IT:  state_next = (it_reg == 4'd15) ? ST_AT_FIN : ST_AT_IT;
            ST_AT_FIN: state_next = ST_ERR;
            ST_ERR: begin
                state_next = (er_mag < 17'(turn_limit_reg)) ? ST_EX_M1 : ST_OUT;
            end
            ST_EX_M1:  state_next = ST_EX_M2;
            ST_EX_M2:  state_next = ex_big ? ST_YW_M1 : ST_EX_M3;
            ST_EX_M3:  state_next = ST_EX_H1;
            ST_EX_H1:  state_next = ST_EX_H2;
            ST_EX_H2:  state_next = (hk_reg == 3'd0) ? ST_EX_END : ST_EX_H1;
            ST_EX_END: state_next = ST_YW_M1;
            ST_YW_M1:  state_next = ST_YW_M2;
            ST_YW_M2:  state_next = ST_YW_SAT;
            ST_YW_SAT: state_next = spd_full ? ST_OUT : ST_SP_M;
            ST_SP_M:   state_next = ST_SP_LD;
            ST_SP_LD:  state_next = ST_SP_DIV;
            ST_SP_DIV: state_next = (it_reg == 4'd0) ? ST_OUT : ST_SP_DIV;
            ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operands.
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ST_SC_MX: begin
                mul_a = 33'(sdx_reg);
                mul_b = 31'(sdx_reg);
            end
            ST_SC_MY: begin
                mul_a = 33'(sdy_reg);
                mul_b = 31'(sdy_reg);
            end
            ST_DS_MX: begin
                mul_a = 33'(sx_reg);
                mul_b = sx_reg;
            end
            ST_DS_MY: begin
                mul_a = 33'(sy_reg);
                mul_b = sy_reg;
            end
            ST_EX_M1: begin
                mul_a = d_reg;
                mul_b = 31'(yaw_decay_reg);
            end
            ST_EX_M2: begin
                mul_a = 33'(mul_p[31:12]);
                mul_b = 31'(LOG2E_Q16);
            end
            ST_EX_H1: begin
                mul_a = 33'(f_reg);
                mul_b = 31'(p_reg);
            end
            ST_YW_M1: begin
                mul_a = 33'(aerr_reg);
                mul_b = 31'(yaw_gain_reg);
            end
            ST_YW_M2: begin
                mul_a = mul_p[32:0];
                mul_b = 31'(e_reg);
            end
            ST_SP_M: begin
                mul_a = d_reg;
                mul_b = 31'(speed_lim_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Path store: written by point words, read during the scan.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_acc && in_kind == KIND_POINT && follow_reg &&
            !held_reg && load_reg < MAX_CNT) begin
            path_mem[load_reg[AW-1:0]] <= {in_y, in_x};
        end
        if (state_reg == ST_SC_RD) begin
            rdata_reg <= path_mem[idx_reg[AW-1:0]];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            load_reg    <= '0;
            search_reg  <= '0;
            held_reg    <= 1'b0;
            follow_reg  <= 1'b0;
            look_x_reg  <= '0;
            look_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // The result register fills from the sequencer and empties on a handshake.
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (in_kind == KIND_POINT) begin
                            if (follow_reg && !held_reg) begin
                                if (load_reg < MAX_CNT) begin
                                    load_reg <= load_reg + CW'(1);
                                    if (s_tlast) begin
                                        search_reg <= load_reg;
                                    end
                                end else if (s_tlast) begin
                                    search_reg <= load_reg - CW'(1);
                                end
                                if (s_tlast) begin
                                    held_reg <= 1'b1;
                                end
                            end
                        end else if (in_kind == KIND_FOLLOW) begin
                            follow_reg <= in_on;
                            if (!in_on) begin
                                search_reg <= '0;
                                held_reg   <= 1'b0;
                                load_reg   <= '0;
                            end
                        end else if (in_kind == KIND_ODOM) begin
                            if (!held_reg || search_reg == '0) begin
                                look_x_reg <= in_x;
                                look_y_reg <= in_y;
                            end
                        end
                    end
                end
                ST_SC_CMP: begin
                    if (sc_hit) begin
                        look_x_reg <= signed'(rdata_reg[31:0]);
                        look_y_reg <= signed'(rdata_reg[63:32]);
                        search_reg <= idx_reg + CW'(1);
                    end
                end
                ST_TGT: begin
                    if (!follow_reg) begin
                        look_x_reg <= px_reg;
                        look_y_reg <= py_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                px_reg  <= in_x;
                py_reg  <= in_y;
                hd_reg  <= in_hd;
                idx_reg <= search_reg;
            end
            ST_SC_RD: begin
                if (scan_skip) begin
                    idx_reg <= idx_reg - CW'(1);
                end
            end
            ST_SC_DIF: begin
                sdx_reg <= sc_adx[16:0];
                sdy_reg <= sc_ady[16:0];
                if (sc_out) begin
                    idx_reg <= idx_reg - CW'(1);
                end
            end
            ST_SC_MY: begin
                acc_reg <= mul_p;
            end
            ST_SC_CMP: begin
                idx_reg <= idx_reg - CW'(1);
            end
            ST_TGT: begin
                dx_neg_reg <= tg_dx[32];
                dy_neg_reg <= tg_dy[32];
                sh_reg     <= tg_sh;
                sx_reg     <= tg_sh ? tg_adx[31:1] : tg_adx[30:0];
                sy_reg     <= tg_sh ? tg_ady[31:1] : tg_ady[30:0];
                cx_reg     <= signed'({1'b0, tg_adx});
                cy_reg     <= signed'({1'b0, tg_ady});
                speed_reg  <= '0;
                yaw_reg    <= '0;
                turn_reg   <= 1'b0;
            end
            ST_DS_MY: begin
                acc_reg <= mul_p;
            end
            ST_DS_SUM: begin
                rad_reg <= 63'(acc_reg + mul_p);
                r_reg   <= '0;
                k_reg   <= 5'd31;
            end
            ST_DS_SQ: begin
                if (64'(rad_reg) >= sq_try) begin
                    rad_reg <= 63'(64'(rad_reg) - sq_try);
                    r_reg   <= (r_reg >> 1) + sq_bit;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                k_reg <= k_reg - 5'd1;
                if (k_reg == 5'd0) begin
                    if (64'(rad_reg) >= sq_try) begin
                        d_reg <= 33'(((r_reg >> 1) + sq_bit) << sh_reg);
                    end else begin
                        d_reg <= 33'((r_reg >> 1) << sh_reg);
                    end
                end
            end
            ST_AT_PRE: begin
                z_reg  <= '0;
                it_reg <= '0;
                if (at_zero) begin
                    angle_reg <= '0;
                end else if (at_big) begin
                    cx_reg <= cx_reg >>> 1;
                    cy_reg <= cy_reg >>> 1;
                end
            end
            ST_AT_IT: begin
                if (!cy_reg[33]) begin
                    cx_reg <= cx_reg + at_ys;
                    cy_reg <= cy_reg - at_xs;
                    z_reg  <= z_reg + 20'(atan_q16(it_reg));
                end else begin
                    cx_reg <= cx_reg - at_ys;
                    cy_reg <= cy_reg + at_xs;
                    z_reg  <= z_reg - 20'(atan_q16(it_reg));
                end
                it_reg <= it_reg + 4'd1;
            end
            ST_AT_FIN: begin
                angle_reg <= dy_neg_reg ? -signed'(at_q) : signed'(at_q);
            end
            ST_ERR: begin
                aerr_reg    <= er_mag[14:0];
                err_neg_reg <= er_wrap[16];
                if (er_mag >= 17'(turn_limit_reg)) begin
                    yaw_reg  <= signed'(turn_rate_reg);
                    turn_reg <= 1'b1;
                end
            end
            ST_EX_M2: begin
                if (ex_big) begin
                    e_reg <= '0;
                end
            end
            ST_EX_M3: begin
                n_reg  <= mul_p[36:32];
                f_reg  <= mul_p[31:16];
                p_reg  <= exp2_coef(3'd6);
                hk_reg <= 3'd5;
            end
            ST_EX_H2: begin
                p_reg  <= exp2_coef(hk_reg) - mul_p[32:16];
                hk_reg <= hk_reg - 3'd1;
            end
            ST_EX_END: begin
                e_reg <= (n_reg >= 5'd17) ? 17'd0 : (p_reg >> n_reg);
            end
            ST_YW_SAT: begin
                yaw_reg <= err_neg_reg ? -signed'({1'b0, yw_sat}) : signed'({1'b0, yw_sat});
                if (spd_full) begin
                    speed_reg <= speed_lim_reg;
                end
            end
            ST_SP_LD: begin
                rem_reg <= mul_p[46:15];
                lo_reg  <= mul_p[14:0];
                q_reg   <= '0;
                it_reg  <= 4'd14;
            end
            ST_SP_DIV: begin
                rem_reg <= dv_ge ? (dv_rem2 - 32'(slow_dist_reg)) : dv_rem2;
                q_reg   <= q_reg | (dv_ge ? (15'd1 << it_reg) : 15'd0);
                it_reg  <= it_reg - 4'd1;
                if (it_reg == 4'd0) begin
                    speed_reg <= q_reg | (dv_ge ? 15'd1 : 15'd0);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    o_speed_reg <= speed_reg;
                    o_yaw_reg   <= yaw_reg;
                    o_turn_reg  <= turn_reg;
                    o_tx_reg    <= look_x_reg;
                    o_ty_reg    <= look_y_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_limit_reg <= 15'd4096;
            turn_rate_reg  <= 16'd4096;
            yaw_gain_reg   <= 15'd4096;
            yaw_decay_reg  <= 15'd4096;
            yaw_limit_reg  <= 15'd4096;
            slow_dist_reg  <= 31'd65536;
            speed_lim_reg  <= 15'd4096;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_TURN_LIMIT: turn_limit_reg <= pwdata[14:0];
                REG_TURN_RATE:  turn_rate_reg  <= pwdata[15:0];
                REG_YAW_GAIN:   yaw_gain_reg   <= pwdata[14:0];
                REG_YAW_DECAY:  yaw_decay_reg  <= pwdata[14:0];
                REG_YAW_LIMIT:  yaw_limit_reg  <= pwdata[14:0];
                REG_SLOW_DIST:  slow_dist_reg  <= pwdata[30:0];
                REG_SPEED_LIM:  speed_lim_reg  <= pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // Configuration reads.
    always_comb begin
        unique case (paddr[4:2])
            REG_TURN_LIMIT: prdata = 32'(turn_limit_reg);
            REG_TURN_RATE:  prdata = 32'(turn_rate_reg);
            REG_YAW_GAIN:   prdata = 32'(yaw_gain_reg);
            REG_YAW_DECAY:  prdata = 32'(yaw_decay_reg);
            REG_YAW_LIMIT:  prdata = 32'(yaw_limit_reg);
            REG_SLOW_DIST:  prdata = 32'(slow_dist_reg);
            REG_SPEED_LIM:  prdata = 32'(speed_lim_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, o_ty_reg, o_tx_reg, o_yaw_reg, o_speed_reg};
    assign m_tuser  = o_turn_reg;

endmodule

// ===== tb/lpf_checker.sv =====
// Watches the input, result and configuration channels of the path follower.
// It predicts each result from the accepted input words and compares them.
module lpf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import lpf_pkg::*;

    localparam int unsigned CAPACITY = MAX_POINTS_DEF;

    typedef struct packed {
        logic [14:0] speed;
        logic [15:0] yaw;
        logic        turning;
        logic [31:0] tgt_x;
        logic [31:0] tgt_y;
    } command_t;

    localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};
    localparam longint POLY_Q16 [7] = '{65536, 45426, 15744, 3638, 630, 87, 10};

    // Predicted block state.
    int          path_x [CAPACITY];
    int          path_y [CAPACITY];
    int unsigned n_loaded;
    int unsigned next_search;
    bit          path_ready;
    bit          follow_en;
    int          aim_x;
    int          aim_y;

    // Shadow copies of the registers.
    int unsigned turn_limit;
    int          turn_rate;
    int unsigned yaw_gain;
    int unsigned yaw_decay;
    int unsigned yaw_limit;
    int unsigned slow_dist;
    int unsigned speed_limit;

    command_t expected_cmds [$];

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint shr_tz(longint v, int s);
        if (v < 0)
            return -longint'(longint'(-v) >> s);
        return v >> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned range_q16(longint dx, longint dy);
        longint unsigned ax;
        longint unsigned ay;
        int s;
        ax = mag(dx);
        ay = mag(dy);
        s = 0;
        if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
            ax >>= 1;
            ay >>= 1;
            s = 1;
        end
        return int_sqrt(ax * ax + ay * ay) << s;
    endfunction

    // Vectoring CORDIC bearing, Q.12 radians.
    function automatic int bearing_q12(longint dy, longint dx);
        longint unsigned ax;
        longint unsigned ay;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int q;
        ax = mag(dx);
        ay = mag(dy);
        if (ax == 0 && ay == 0)
            return 0;
        while (ax >= (64'd1 << 29) || ay >= (64'd1 << 29)) begin
            ax >>= 1;
            ay >>= 1;
        end
        x = ax;
        y = ay;
        z = 0;
        for (int i = 0; i < 16; i++) begin
            xs = shr_tz(x, i);
            ys = shr_tz(y, i);
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += ATAN_Q16[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ATAN_Q16[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(HALF_PI_Q16))
            z = HALF_PI_Q16;
        if (dx < 0)
            z = longint'(PI_Q16) - z;
        q = int'((z + 8) >>> 4);
        return (dy < 0) ? -q : q;
    endfunction

    // exp(-kd*d) in Q.16 via 2^-x polynomial.
    function automatic longint unsigned decay_q16(longint unsigned kd, longint unsigned d);
        longint unsigned x;
        longint unsigned y;
        longint unsigned f;
        longint unsigned n;
        longint p;
        x = (kd * d) >> 12;
        if (x >= (64'd16 << 16))
            return 0;
        y = (x * 64'd94548) >> 16;
        n = y >> 16;
        f = y & 64'hFFFF;
        p = POLY_Q16[6];
        for (int k = 5; k >= 0; k--)
            p = POLY_Q16[k] - longint'((f * longint'(p)) >> 16);
        if (n >= 17)
            return 0;
        return longint'(p) >> n;
    endfunction

    // Lookahead search over the held path.
    function automatic void search_path(int px, int py);
        longint dx;
        longint dy;
        longint unsigned sq;
        if (!path_ready || next_search == 0) begin
            aim_x = px;
            aim_y = py;
            return;
        end
        for (int unsigned i = next_search; i > 0; i--) begin
            if (i >= n_loaded || i >= CAPACITY)
                continue;
            dx = longint'(path_x[i]) - longint'(px);
            dy = longint'(path_y[i]) - longint'(py);
            if (mag(dx) >= (64'd2 << 16) || mag(dy) >= (64'd2 << 16))
                continue;
            sq = dx * dx + dy * dy;
            if (sq > (64'd1 << 30) && sq < (64'd1 << 34)) begin
                aim_x = path_x[i];
                aim_y = path_y[i];
                next_search = i + 1;
            end
        end
    endfunction

    // Steering command for one odometry word.
    function automatic command_t steer(int px, int py, int head);
        command_t c;
        longint dx;
        longint dy;
        longint unsigned d;
        longint unsigned e;
        longint unsigned m;
        longint v;
        int err;
        c = '0;
        search_path(px, py);
        if (!follow_en) begin
            aim_x = px;
            aim_y = py;
        end else begin
            dx = longint'(aim_x) - longint'(px);
            dy = longint'(aim_y) - longint'(py);
            err = bearing_q12(dy, dx) - head;
            d = range_q16(dx, dy);
            if (err > int'(PI_Q12))
                err -= int'(TWO_PI_Q12);
            else if (err < -int'(PI_Q12))
                err += int'(TWO_PI_Q12);
            if (mag(err) < turn_limit) begin
                e = decay_q16(yaw_decay, d);
                m = (longint'(yaw_gain) * mag(err) * e + (64'd1 << 27)) >> 28;
                v = (err < 0) ? -longint'(m) : longint'(m);
                if (v >= longint'(yaw_limit))
                    v = yaw_limit;
                else if (v <= -longint'(yaw_limit))
                    v = -longint'(yaw_limit);
                c.yaw = v[15:0];
                if (d >= slow_dist)
                    c.speed = speed_limit[14:0];
                else
                    c.speed = 15'((longint'(speed_limit) * d) / slow_dist);
            end else begin
                c.yaw = turn_rate[15:0];
                c.turning = 1'b1;
            end
        end
        c.tgt_x = aim_x;
        c.tgt_y = aim_y;
        return c;
    endfunction

    assign pending = expected_cmds.size();

    always @(posedge aclk) begin
        command_t got;
        command_t want;
        int px;
        int py;
        int head;
        if (!aresetn) begin
            n_loaded    <= 0;
            next_search <= 0;
            path_ready  <= 0;
            follow_en   <= 0;
            aim_x       <= 0;
            aim_y       <= 0;
            turn_limit  <= 4096;
            turn_rate   <= 4096;
            yaw_gain    <= 4096;
            yaw_decay   <= 4096;
            yaw_limit   <= 4096;
            slow_dist   <= 65536;
            speed_limit <= 4096;
            fail_count  <= 0;
            checked     <= 0;
            expected_cmds.delete();
        end else begin
            // Register writes.
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_TURN_LIMIT: turn_limit  = pwdata[14:0];
                    REG_TURN_RATE:  turn_rate   = int'($signed(pwdata[15:0]));
                    REG_YAW_GAIN:   yaw_gain    = pwdata[14:0];
                    REG_YAW_DECAY:  yaw_decay   = pwdata[14:0];
                    REG_YAW_LIMIT:  yaw_limit   = pwdata[14:0];
                    REG_SLOW_DIST:  slow_dist   = pwdata[30:0];
                    REG_SPEED_LIM:  speed_limit = pwdata[14:0];
                    default: ;
                endcase
            end

            // Compare a delivered result with the oldest prediction.
            if (m_tvalid && m_tready) begin
                got.speed   = m_tdata[14:0];
                got.yaw     = m_tdata[30:15];
                got.tgt_x   = m_tdata[62:31];
                got.tgt_y   = m_tdata[94:63];
                got.turning = m_tuser;
                if (expected_cmds.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected result word: %h turning %b", m_tdata, m_tuser);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_cmds.pop_front();
                    checked = checked + 1;
                    if (got !== want || m_tdata[95] !== 1'b0) begin
                        if (fail_count < 10) begin
                            $display("Result %0d want speed %0d yaw %0d turn %b at %h,%h",
                                     checked, want.speed, $signed(want.yaw), want.turning,
                                     want.tgt_x, want.tgt_y);
                            $display("           got speed %0d yaw %0d turn %b at %h,%h",
                                     got.speed, $signed(got.yaw), got.turning,
                                     got.tgt_x, got.tgt_y);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end

            // Advance the prediction on each accepted input word.
            if (s_tvalid && s_tready) begin
                px   = s_tdata[31:0];
                py   = s_tdata[63:32];
                head = int'($signed(s_tdata[78:64]));
                case (s_tuser)
                    KIND_POINT: begin
                        if (follow_en && !path_ready) begin
                            if (n_loaded < CAPACITY) begin
                                path_x[n_loaded] = px;
                                path_y[n_loaded] = py;
                                n_loaded = n_loaded + 1;
                            end
                            if (s_tlast) begin
                                next_search = n_loaded - 1;
                                path_ready  = 1;
                            end
                        end
                    end
                    KIND_FOLLOW: begin
                        if (s_tdata[79]) begin
                            follow_en = 1;
                        end else begin
                            follow_en   = 0;
                            next_search = 0;
                            path_ready  = 0;
                            n_loaded    = 0;
                        end
                    end
                    KIND_ODOM: expected_cmds = {expected_cmds, steer(px, py, head)};
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/lookahead_path_follower_tb.sv =====
module lookahead_path_follower_tb;
    import lpf_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int METER = 65536;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = KIND_POINT;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int words_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #5 aclk = ~aclk;

    lookahead_path_follower u_top (.*);

    lpf_checker u_checker (.*);

    // Result side back-pressure.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Send one input word, with random idle cycles ahead of it.
    task automatic send_word(logic [1:0] kind, int px, int py, int head, bit last, bit on);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {on, 15'(head), 32'(py), 32'(px)};
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // Let every outstanding result drain before touching registers.
    task automatic drain;
        s_tvalid <= 0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic int rand_heading();
        return int'($urandom_range(25736)) - 12868;
    endfunction

    function automatic int rand_offset(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Load a path of n points from an origin with a fixed step.
    task automatic load_path(int x0, int y0, int n, int sx, int sy);
        for (int k = 0; k < n; k++)
            send_word(KIND_POINT, x0 + k * sx, y0 + k * sy, rand_heading(), k == n - 1, 1);
    endtask

    task automatic directed_items;
        send_word(KIND_ODOM, 32'h7FFF_FFFF, 32'h8000_0000, 12868, 1, 1);
        send_word(KIND_POINT, 0, 0, 0, 1, 1);
        send_word(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, 1, 1);
        send_word(KIND_FOLLOW, 0, 0, 0, 0, 1);
        send_word(KIND_ODOM, 32'h8000_0000, 32'h7FFF_FFFF, -12868, 0, 0);
        load_path(0, 0, 6, METER / 2, 0);
        send_word(KIND_POINT, 5 * METER, 5 * METER, 0, 1, 1);
        send_word(KIND_ODOM, 0, 0, 0, 0, 0);
        send_word(KIND_ODOM, METER, METER / 3, 6434, 0, 0);
        send_word(KIND_ODOM, -METER, -METER, -12868, 0, 0);
        send_word(KIND_ODOM, 100 * METER, 0, 0, 0, 0);
        send_word(KIND_ODOM, 2 * METER, -METER / 2, 12868, 0, 0);
        send_word(KIND_FOLLOW, 0, 0, 0, 0, 0);
        send_word(KIND_ODOM, -7 * METER, 3 * METER, 100, 0, 0);
        send_word(KIND_FOLLOW, 0, 0, 0, 0, 1);
        send_word(KIND_ODOM, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_word(KIND_ODOM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    endtask

    // Mostly well formed follow sequences, with some noise.
    task automatic random_items(int count);
        int stop;
        int n;
        int x0;
        int y0;
        int sx;
        int sy;
        int j;
        int r;
        stop = words_sent + count;
        while (words_sent < stop) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_word(2'($urandom_range(3)), $urandom, $urandom, rand_heading(),
                          $urandom_range(1), $urandom_range(1));
            end else if (r < 14) begin
                send_word(KIND_FOLLOW, $urandom, $urandom, rand_heading(), 0,
                          $urandom_range(1));
            end else begin
                send_word(KIND_FOLLOW, 0, 0, 0, 0, 1);
                n = $urandom_range(2, 24);
                if ($urandom_range(4) == 0) begin
                    x0 = $urandom;
                    y0 = $urandom;
                end else begin
                    x0 = rand_offset(8 * METER);
                    y0 = rand_offset(8 * METER);
                end
                sx = rand_offset(METER);
                sy = rand_offset(METER);
                load_path(x0, y0, n, sx, sy);
                repeat ($urandom_range(1, 8)) begin
                    j = $urandom_range(n - 1);
                    send_word(KIND_ODOM, x0 + j * sx + rand_offset(5 * METER / 2),
                              y0 + j * sy + rand_offset(5 * METER / 2), rand_heading(), 0, 0);
                end
                if ($urandom_range(9) < 3)
                    send_word(KIND_FOLLOW, 0, 0, 0, 0, 0);
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Register defaults, no idling.
        directed_items();
        random_items(55);
        drain();

        // Largest register values, idle sender.
        reg_write(REG_TURN_LIMIT, 32767);
        reg_write(REG_TURN_RATE, 32767);
        reg_write(REG_YAW_GAIN, 32767);
        reg_write(REG_YAW_DECAY, 32767);
        reg_write(REG_YAW_LIMIT, 32767);
        reg_write(REG_SLOW_DIST, 32'h7FFF_FFFF);
        reg_write(REG_SPEED_LIM, 32767);
        send_idle_pct = 79;
        random_items(55);
        drain();

        // Smallest register values, stalling receiver.
        reg_write(REG_TURN_LIMIT, 0);
        reg_write(REG_TURN_RATE, 32'h0000_8000);
        reg_write(REG_YAW_GAIN, 0);
        reg_write(REG_YAW_DECAY, 0);
        reg_write(REG_YAW_LIMIT, 0);
        reg_write(REG_SLOW_DIST, 1);
        reg_write(REG_SPEED_LIM, 0);
        send_idle_pct = 0;
        recv_stall_pct = 79;
        random_items(55);
        drain();

        // Random register values, both sides idling.
        reg_write(REG_TURN_LIMIT, $urandom_range(1000, 14000));
        reg_write(REG_TURN_RATE, $urandom_range(65535));
        reg_write(REG_YAW_GAIN, $urandom_range(32767));
        reg_write(REG_YAW_DECAY, $urandom_range(32767));
        reg_write(REG_YAW_LIMIT, $urandom_range(32767));
        reg_write(REG_SLOW_DIST, $urandom_range(1, 4 * METER));
        reg_write(REG_SPEED_LIM, $urandom_range(32767));
        reg_write(REG_UNUSED, $urandom);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        random_items(55);
        drain();

        $display("Sent %0d input words over four register settings and idle patterns.",
                 words_sent);
        $display("Checked %0d steering results against the predicted commands.", checked);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog.
    initial begin
        #50000000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lpf_pkg.sv
rtl/lpf_mul.sv
rtl/lookahead_path_follower.sv
tb/lpf_checker.sv
tb/lookahead_path_follower_tb.sv
